// ----- rtl/core/gmm_pkg.sv -----
// Shared types and constants for the Gaussian moment multiply-accumulate.
`default_nettype none
package gmm_pkg;

   localparam int IN_FRAC    = 12;
   localparam int ACC_W      = 48;
   localparam int VAR_W      = 47;
   localparam int VAR_ADD_W  = 49;
   localparam int TERM_W     = 61;
   localparam int CHUNK_W    = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_BIAS_ENABLE = 1'b0;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_MEAN  = 10'b00_0000_0010,
      ST_WSQ   = 10'b00_0000_0100,
      ST_ASQ   = 10'b00_0000_1000,
      ST_COEF  = 10'b00_0001_0000,
      ST_AVAR  = 10'b00_0010_0000,
      ST_DRAIN = 10'b00_0100_0000,
      ST_ROUND = 10'b00_1000_0000,
      ST_BIAS  = 10'b01_0000_0000,
      ST_EMIT  = 10'b10_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_MEAN,
      TAG_WSQ,
      TAG_ASQ,
      TAG_TERM
   } tag_type;

   typedef struct packed {
      logic               clear;
      logic               add;
      logic [CHUNK_W-1:0] chunk;
   } term_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/core/gmm_term_acc.sv -----
// Saturating accumulator for the variance term, fed one shifted partial product a cycle.
`default_nettype none
module gmm_term_acc #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  gmm_pkg::term_ctl_type         ctl,
   input  logic [2*DATA_WIDTH-1:0]       prod,
   output logic [gmm_pkg::TERM_W-1:0]    term
);
   import gmm_pkg::*;

   localparam int CW  = ((2*DATA_WIDTH-2 > DATA_WIDTH+IN_FRAC) ?
                         (2*DATA_WIDTH-2) : (DATA_WIDTH+IN_FRAC)) + 1;
   localparam int NCH = (CW + DATA_WIDTH - 1) / DATA_WIDTH;
   localparam int XW0 = (NCH + 1) * DATA_WIDTH;
   localparam int XW  = (XW0 > TERM_W + 1) ? XW0 : (TERM_W + 1);

   localparam logic [TERM_W-1:0] CAP   = {1'b1, {(TERM_W-1){1'b0}}};
   localparam logic [XW-1:0]     CAP_X = XW'(CAP);

   logic [TERM_W-1:0] term_ff;
   logic [TERM_W-1:0] term_in;
   logic [XW-1:0]     shifted;
   logic [TERM_W-1:0] addend;
   logic [TERM_W:0]   sum;

   assign shifted = XW'(prod) << (DATA_WIDTH * int'(ctl.chunk));
   assign addend  = (shifted > CAP_X) ? CAP : shifted[TERM_W-1:0];
   assign sum     = {1'b0, term_ff} + {1'b0, addend};

   always_comb begin
      term_in = term_ff;
      if (ctl.clear) begin
         term_in = '0;
      end else if (ctl.add) begin
         term_in = (sum > {1'b0, CAP}) ? CAP : sum[TERM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule
`default_nettype wire

// ----- rtl/core/gaussian_moment_mac.sv -----
// Gaussian moment MAC: one shared multiplier sequenced over the mean and variance products.
// NCH = coefficient chunks (2 at DATA_WIDTH 16, 3 at DATA_WIDTH 7 to 12); each tap needs
// 5+NCH products on the single multiplier, and a new tap is taken only once the previous one
// is through ROUND (a last tap also through BIAS and EMIT).
// A result waits in the output register while the next taps are taken.
// Synchronous reset: idle, no result pending, sums zero, bias_enable 1.
`default_nettype none
module gaussian_moment_mac #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [DATA_WIDTH-1:0]         req_weight_mean,
   input  logic        [DATA_WIDTH-1:0]         req_weight_var,
   input  logic signed [DATA_WIDTH-1:0]         req_act_mean,
   input  logic        [DATA_WIDTH-1:0]         req_act_var,
   input  logic                                 req_tap_valid,
   input  logic signed [DATA_WIDTH-1:0]         req_bias_mean,
   input  logic        [DATA_WIDTH-1:0]         req_bias_var,
   input  logic                                 req_last_tap,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gmm_pkg::ACC_W-1:0]     rsp_out_mean,
   output logic        [gmm_pkg::VAR_W-1:0]     rsp_out_var,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic        [gmm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic        [gmm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic        [gmm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import gmm_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int CW   = ((2*DW-2 > DW+IN_FRAC) ? (2*DW-2) : (DW+IN_FRAC)) + 1;
   localparam int NCH  = (CW + DW - 1) / DW;
   localparam int CP   = NCH * DW;
   localparam int MOPW = ((2*DW+1 > DW+IN_FRAC+1) ? (2*DW+1) : (DW+IN_FRAC+1));
   localparam int MSW  = ((ACC_W > MOPW) ? ACC_W : MOPW) + 1;
   localparam int VSW  = VAR_ADD_W + 1;

   localparam logic [CHUNK_W-1:0] LAST_CHUNK  = CHUNK_W'(NCH - 1);
   localparam logic [CHUNK_W-1:0] LAST_SQUARE = CHUNK_W'(1);
   localparam logic signed [MSW-1:0] MEAN_MAX = MSW'({1'b0, {(ACC_W-1){1'b1}}});
   localparam logic signed [MSW-1:0] MEAN_MIN = ~MEAN_MAX;
   localparam logic [VSW-1:0]        VAR_MAX  = VSW'({VAR_W{1'b1}});
   localparam logic [TERM_W:0]       RND_HALF = (TERM_W+1)'(1) << (IN_FRAC - 1);

   state_type              state_ff, state_in;
   logic [CHUNK_W-1:0]     cnt_ff, cnt_in;
   tag_type                tag_ff, tag_in;
   logic [CHUNK_W-1:0]     chunk_ff, chunk_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   bias_en_ff, bias_en_in;
   logic signed [ACC_W-1:0] mean_sum_ff, mean_sum_in;
   logic [VAR_W-1:0]       var_sum_ff, var_sum_in;

   logic [DW-1:0]          wm_mag_ff, am_mag_ff, wv_ff, av_ff, bv_ff;
   logic signed [DW-1:0]   bm_ff;
   logic                   neg_ff, tap_valid_ff, last_ff;
   logic [2*DW-1:0]        prod_ff, prod_in;
   logic signed [MOPW-1:0] mterm_ff;
   logic [CP-1:0]          coef_ff;
   logic [2*DW-1:0]        am2_ff;
   logic signed [ACC_W-1:0] out_mean_ff;
   logic [VAR_W-1:0]       out_var_ff;

   logic [DW-1:0]          wm_raw, am_raw, mul_a, mul_b;
   logic [MOPW-1:0]        prod_mag;
   logic                   accept, emit_fire, csr_wr;
   term_ctl_type           term_ctl;
   logic [TERM_W-1:0]      term;
   logic [TERM_W:0]        rnd_sum;
   logic [VAR_ADD_W-1:0]   rounded, var_opd;
   logic signed [MOPW-1:0] bias_sh, mean_opd;
   logic signed [MSW-1:0]  mean_wide;
   logic [VSW-1:0]         var_wide;
   logic                   do_add;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;

   assign wm_raw = req_weight_mean;
   assign am_raw = req_act_mean;

   always_comb begin
      mul_a          = '0;
      mul_b          = '0;
      tag_in         = TAG_NONE;
      chunk_in       = '0;
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            mul_a    = wm_mag_ff;
            mul_b    = am_mag_ff;
            tag_in   = TAG_MEAN;
            state_in = ST_WSQ;
         end
         ST_WSQ: begin
            mul_a    = wm_mag_ff;
            mul_b    = wm_mag_ff;
            tag_in   = TAG_WSQ;
            state_in = ST_ASQ;
         end
         ST_ASQ: begin
            mul_a    = am_mag_ff;
            mul_b    = am_mag_ff;
            tag_in   = TAG_ASQ;
            cnt_in   = '0;
            state_in = ST_COEF;
         end
         ST_COEF: begin
            mul_a    = coef_ff[DW*int'(cnt_ff) +: DW];
            mul_b    = av_ff;
            tag_in   = TAG_TERM;
            chunk_in = cnt_ff;
            if (cnt_ff == LAST_CHUNK) begin
               cnt_in   = '0;
               state_in = ST_AVAR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_AVAR: begin
            mul_a    = am2_ff[DW*int'(cnt_ff[0]) +: DW];
            mul_b    = wv_ff;
            tag_in   = TAG_TERM;
            chunk_in = cnt_ff;
            if (cnt_ff == LAST_SQUARE) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = last_ff ? ST_BIAS : ST_IDLE;
         end
         ST_BIAS: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign term_ctl.clear = accept;
   assign term_ctl.add   = (tag_ff == TAG_TERM);
   assign term_ctl.chunk = chunk_ff;

   gmm_term_acc #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_term_acc (
      .clock (clock),
      .ctl   (term_ctl),
      .prod  (prod_ff),
      .term  (term)
   );

   assign rnd_sum  = {1'b0, term} + RND_HALF;
   assign rounded  = rnd_sum[IN_FRAC +: VAR_ADD_W];
   assign prod_mag = MOPW'(prod_ff);
   assign bias_sh  = MOPW'(bm_ff) <<< IN_FRAC;

   assign mean_opd  = (state_ff == ST_BIAS) ? bias_sh : mterm_ff;
   assign var_opd   = (state_ff == ST_BIAS) ? (VAR_ADD_W'(bv_ff) << IN_FRAC) : rounded;
   assign mean_wide = MSW'(mean_sum_ff) + MSW'(mean_opd);
   assign var_wide  = VSW'(var_sum_ff) + VSW'(var_opd);
   assign do_add    = ((state_ff == ST_ROUND) && tap_valid_ff) ||
                      ((state_ff == ST_BIAS) && bias_en_ff);

   always_comb begin
      mean_sum_in = mean_sum_ff;
      var_sum_in  = var_sum_ff;
      if (emit_fire) begin
         mean_sum_in = '0;
         var_sum_in  = '0;
      end else if (do_add) begin
         if (mean_wide > MEAN_MAX) begin
            mean_sum_in = MEAN_MAX[ACC_W-1:0];
         end else if (mean_wide < MEAN_MIN) begin
            mean_sum_in = MEAN_MIN[ACC_W-1:0];
         end else begin
            mean_sum_in = mean_wide[ACC_W-1:0];
         end
         var_sum_in = (var_wide > VAR_MAX) ? VAR_MAX[VAR_W-1:0] : var_wide[VAR_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      bias_en_in = bias_en_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_BIAS_ENABLE)) begin
         bias_en_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tag_ff       <= TAG_NONE;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         bias_en_ff   <= 1'b1;
         mean_sum_ff  <= '0;
         var_sum_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tag_ff       <= tag_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
         bias_en_ff   <= bias_en_in;
         mean_sum_ff  <= mean_sum_in;
         var_sum_ff   <= var_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wm_mag_ff    <= wm_raw[DW-1] ? (~wm_raw + 1'b1) : wm_raw;
         am_mag_ff    <= am_raw[DW-1] ? (~am_raw + 1'b1) : am_raw;
         neg_ff       <= wm_raw[DW-1] ^ am_raw[DW-1];
         wv_ff        <= req_weight_var;
         av_ff        <= req_act_var;
         bm_ff        <= req_bias_mean;
         bv_ff        <= req_bias_var;
         tap_valid_ff <= req_tap_valid;
         last_ff      <= req_last_tap;
      end
      prod_ff <= prod_in;
      case (tag_ff)
         TAG_MEAN: begin
            mterm_ff <= neg_ff ? -signed'(prod_mag) : signed'(prod_mag);
         end
         TAG_WSQ: begin
            coef_ff <= CP'(prod_ff) + (CP'(wv_ff) << IN_FRAC);
         end
         TAG_ASQ: begin
            am2_ff <= prod_ff;
         end
         default: begin
            am2_ff <= am2_ff;
         end
      endcase
      if (emit_fire) begin
         out_mean_ff <= mean_sum_ff;
         out_var_ff  <= var_sum_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_mean = out_mean_ff;
   assign rsp_out_var  = out_var_ff;
   assign csr_pready   = 1'b1;
   assign csr_prdata   = (csr_paddr[2] == CSR_IDX_BIAS_ENABLE) ?
                         CSR_DATA_W'(bias_en_ff) : '0;

endmodule
`default_nettype wire

// ----- rtl/core/gmm_checker.sv -----
// Port-level checks for the Gaussian moment MAC, bound to the top level.
`default_nettype none
module gmm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [gmm_pkg::ACC_W-1:0]     rsp_out_mean,
   input logic        [gmm_pkg::VAR_W-1:0]     rsp_out_var,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic        [gmm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic        [gmm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic        [gmm_pkg::CSR_DATA_W-1:0] csr_prdata
);
   import gmm_pkg::*;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a word is still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_mean) && $stable(rsp_out_var))
      else $error("stalled result word changed or dropped");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not return to idle");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_BIAS_ENABLE)
      |=> csr_paddr[2] != CSR_IDX_BIAS_ENABLE || csr_prdata[0] == $past(csr_pwdata[0]))
      else $error("bias_enable readback mismatch");

endmodule

bind gaussian_moment_mac gmm_checker u_gmm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_mean (rsp_out_mean),
   .rsp_out_var  (rsp_out_var),
   .csr_psel     (csr_psel),
   .csr_penable  (csr_penable),
   .csr_pwrite   (csr_pwrite),
   .csr_paddr    (csr_paddr),
   .csr_pwdata   (csr_pwdata),
   .csr_prdata   (csr_prdata)
);
`default_nettype wire

// ----- tb/gaussian_moment_mac_tb.sv -----
// Self-checking testbench for the Gaussian moment MAC: tap stimulus, moment prediction and checks.
module gaussian_moment_mac_tb;
   import gmm_pkg::*;

   localparam int DW = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD = 400;
   localparam int PEAK_TAPS = 12;
   localparam logic [CSR_ADDR_W-1:0] BIAS_ENABLE_ADDR = {CSR_IDX_BIAS_ENABLE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;
   localparam longint MEAN_MAX = 64'sd140737488355327;
   localparam longint MEAN_MIN = -64'sd140737488355328;
   localparam longint unsigned VAR_MAX = 64'd140737488355327;
   localparam longint unsigned TERM_LIMIT = 64'd1 << 60;

   typedef struct {
      logic signed [DW-1:0] weight_mean;
      logic        [DW-1:0] weight_var;
      logic signed [DW-1:0] act_mean;
      logic        [DW-1:0] act_var;
      logic                 tap_valid;
      logic signed [DW-1:0] bias_mean;
      logic        [DW-1:0] bias_var;
      logic                 last_tap;
   } tap_type;

   typedef struct {
      logic signed [ACC_W-1:0] out_mean;
      logic        [VAR_W-1:0] out_var;
   } moment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [DW-1:0]        req_weight_mean = '0;
   logic        [DW-1:0]        req_weight_var = '0;
   logic signed [DW-1:0]        req_act_mean = '0;
   logic        [DW-1:0]        req_act_var = '0;
   logic                        req_tap_valid = 1'b0;
   logic signed [DW-1:0]        req_bias_mean = '0;
   logic        [DW-1:0]        req_bias_var = '0;
   logic                        req_last_tap = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [ACC_W-1:0]     rsp_out_mean;
   logic        [VAR_W-1:0]     rsp_out_var;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic        [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic        [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic        [CSR_DATA_W-1:0] csr_prdata;
   logic                        csr_pready;

   tap_type         pending_taps[$];
   moment_type      expected_moments[$];
   tap_type         cur_tap;
   moment_type      want;
   logic            holding = 1'b0;
   logic            quiet = 1'b0;
   logic            bias_on = 1'b1;
   longint          mean_acc = 0;
   longint unsigned var_acc = 0;
   int              send_gap = 0;
   int              ready_gap = 0;
   int              stall_left = 0;
   int              hold_token = 0;
   int              hold_seen = 0;
   int              error_count = 0;

   gaussian_moment_mac #(.DATA_WIDTH(DW)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_weight_mean (req_weight_mean),
      .req_weight_var  (req_weight_var),
      .req_act_mean    (req_act_mean),
      .req_act_var     (req_act_var),
      .req_tap_valid   (req_tap_valid),
      .req_bias_mean   (req_bias_mean),
      .req_bias_var    (req_bias_var),
      .req_last_tap    (req_last_tap),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_mean    (rsp_out_mean),
      .rsp_out_var     (rsp_out_var),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void add_mean(input longint delta);
      longint s;
      s = mean_acc + delta;
      if (s > MEAN_MAX) s = MEAN_MAX;
      if (s < MEAN_MIN) s = MEAN_MIN;
      mean_acc = s;
   endfunction

   function automatic void add_var(input longint unsigned delta);
      longint unsigned s;
      s = var_acc + delta;
      var_acc = (s > VAR_MAX) ? VAR_MAX : s;
   endfunction

   function automatic void accumulate_tap(input tap_type t);
      longint          wm, am, bm;
      longint unsigned wv, av, bv, wm_sq, am_sq, term;
      moment_type      res;
      wm = t.weight_mean;
      am = t.act_mean;
      bm = t.bias_mean;
      wv = t.weight_var;
      av = t.act_var;
      bv = t.bias_var;
      if (t.tap_valid) begin
         wm_sq = (wm < 0) ? -wm : wm;
         wm_sq = wm_sq * wm_sq;
         am_sq = (am < 0) ? -am : am;
         am_sq = am_sq * am_sq;
         term = (wm_sq + (wv << IN_FRAC)) * av + wv * am_sq;
         if (term > TERM_LIMIT) term = TERM_LIMIT;
         add_mean(wm * am);
         add_var((term + (64'd1 << (IN_FRAC - 1))) >> IN_FRAC);
      end
      if (t.last_tap) begin
         if (bias_on) begin
            add_mean(bm * (64'sd1 <<< IN_FRAC));
            add_var(bv << IN_FRAC);
         end
         res.out_mean = mean_acc[ACC_W-1:0];
         res.out_var  = var_acc[VAR_W-1:0];
         expected_moments.push_back(res);
         mean_acc = 0;
         var_acc = 0;
      end
   endfunction

   function automatic tap_type mk_tap(input logic [DW-1:0] wm, input logic [DW-1:0] wv,
                                      input logic [DW-1:0] am, input logic [DW-1:0] av,
                                      input logic vld, input logic [DW-1:0] bm,
                                      input logic [DW-1:0] bv, input logic last);
      tap_type t;
      t.weight_mean = wm;
      t.weight_var  = wv;
      t.act_mean    = am;
      t.act_var     = av;
      t.tap_valid   = vld;
      t.bias_mean   = bm;
      t.bias_var    = bv;
      t.last_tap    = last;
      return t;
   endfunction

   function automatic logic [DW-1:0] pick_field();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'h7FFF;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return DW'($urandom);
      endcase
   endfunction

   // push random neurons of 1..12 taps until about n taps are queued
   task automatic queue_neurons(input int n);
      int count;
      int len;
      count = 0;
      while (count < n) begin
         len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
         for (int i = 0; i < len; i++) begin
            pending_taps.push_back(mk_tap(pick_field(), pick_field(), pick_field(),
                                          pick_field(), $urandom_range(0, 6) != 0,
                                          pick_field(), pick_field(), i == len - 1));
         end
         count += len;
      end
   endtask

   task automatic wait_idle();
      while (pending_taps.size() != 0 || holding || expected_moments.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == BIAS_ENABLE_ADDR) bias_on = data[0];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         holding = 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            accumulate_tap(cur_tap);
            holding = 1'b0;
         end
         if (!holding) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_taps.size() != 0) begin
               cur_tap = pending_taps.pop_front();
               holding = 1'b1;
               req_weight_mean <= cur_tap.weight_mean;
               req_weight_var  <= cur_tap.weight_var;
               req_act_mean    <= cur_tap.act_mean;
               req_act_var     <= cur_tap.act_var;
               req_tap_valid   <= cur_tap.tap_valid;
               req_bias_mean   <= cur_tap.bias_mean;
               req_bias_var    <= cur_tap.bias_var;
               req_last_tap    <= cur_tap.last_tap;
               if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 10);
            end
         end
         req_valid <= holding;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_gap = 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_moments.size() == 0) begin
               $error("unexpected word: out_mean %0d out_var %0d", rsp_out_mean, rsp_out_var);
               error_count++;
            end else begin
               want = expected_moments.pop_front();
               if (rsp_out_mean !== want.out_mean) begin
                  $error("out_mean: expected %0d, actual %0d", want.out_mean, rsp_out_mean);
                  error_count++;
               end
               if (rsp_out_var !== want.out_var) begin
                  $error("out_var: expected %0d, actual %0d", want.out_var, rsp_out_var);
                  error_count++;
               end
            end
         end
         if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            stall_left = LONG_HOLD;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (ready_gap != 0) begin
            ready_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) ready_gap = $urandom_range(1, 10);
         end
      end
   end

   initial begin
      #(8 * 1000000);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // bias off; upper data bits dropped
      csr_write(BIAS_ENABLE_ADDR, 32'hFFFF_FFFE);
      pending_taps.push_back(mk_tap(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                    16'h7FFF, 16'hFFFF, 1'b1));
      pending_taps.push_back(mk_tap(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 1'b1,
                                    16'h0000, 16'h0000, 1'b0));
      pending_taps.push_back(mk_tap(16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1,
                                    16'h8000, 16'hFFFF, 1'b0));
      pending_taps.push_back(mk_tap(16'h8000, 16'h0001, 16'h7FFF, 16'h0001, 1'b1,
                                    16'h0000, 16'h0000, 1'b0));
      pending_taps.push_back(mk_tap(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
                                    16'hFFFF, 16'hFFFF, 1'b0));
      pending_taps.push_back(mk_tap(16'h0020, 16'h0000, 16'h0000, 16'h0002, 1'b1,
                                    16'h0000, 16'h0000, 1'b1));
      pending_taps.push_back(mk_tap(16'h0001, 16'h0000, 16'h0000, 16'h07FF, 1'b1,
                                    16'h0000, 16'h0000, 1'b1));
      pending_taps.push_back(mk_tap(16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b0,
                                    16'h8000, 16'hFFFF, 1'b1));
      wait_idle();

      // spare register index: must not touch bias_enable
      csr_write(SPARE_ADDR, 32'hFFFF_FFFF);
      pending_taps.push_back(mk_tap(16'h0001, 16'h0001, 16'hFFFF, 16'h0001, 1'b1,
                                    16'h7FFF, 16'hFFFF, 1'b1));
      wait_idle();

      csr_write(BIAS_ENABLE_ADDR, 32'h0000_0001);
      pending_taps.push_back(mk_tap(16'h0001, 16'h0000, 16'h0001, 16'h0000, 1'b1,
                                    16'h8000, 16'hFFFF, 1'b1));
      pending_taps.push_back(mk_tap(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0,
                                    16'h7FFF, 16'hFFFF, 1'b1));
      pending_taps.push_back(mk_tap(16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1,
                                    16'h8000, 16'h0000, 1'b1));
      pending_taps.push_back(mk_tap(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b1,
                                    16'h0000, 16'h0000, 1'b0));
      pending_taps.push_back(mk_tap(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000, 1'b1,
                                    16'h7FFF, 16'h0000, 1'b1));
      wait_idle();

      // hold off the result side while taps keep coming
      hold_token++;
      queue_neurons(170);
      wait_idle();

      csr_write(BIAS_ENABLE_ADDR, 32'h0000_0000);
      queue_neurons(170);
      wait_idle();

      csr_write(BIAS_ENABLE_ADDR, 32'h8000_0001);
      queue_neurons(170);
      wait_idle();

      // no idling from here on; one neuron of full-scale taps
      quiet = 1'b1;
      for (int i = 0; i < PEAK_TAPS; i++) begin
         pending_taps.push_back(mk_tap(16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1,
                                       16'h7FFF, 16'hFFFF, i == PEAK_TAPS - 1));
      end
      queue_neurons(40);
      wait_idle();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- gaussian_moment_mac.f -----
rtl/core/gmm_pkg.sv
rtl/core/gmm_term_acc.sv
rtl/core/gaussian_moment_mac.sv
rtl/core/gmm_checker.sv
tb/gaussian_moment_mac_tb.sv
